### src/rtr_pkg.sv
// ----------------------------------------------------------------------------
// Reliable transfer receiver package
// Shared constants, flag masks, reply kinds and the structures passed between
// the frame parser, the receiver rules and the result queue.
// ----------------------------------------------------------------------------
package rtr_pkg;

    localparam int FRAME_WORDS_DEF   = 520;
    localparam int PAYLOAD_BYTES_DEF = 1024;
    localparam int Q_DEPTH           = 4;

    localparam int WORD_SEQ_LO = 0;
    localparam int WORD_SEQ_HI = 1;
    localparam int WORD_FLAGS  = 4;
    localparam int WORD_LENGTH = 5;
    localparam int WORD_CSUM   = 6;

    localparam logic [15:0] FL_SYN      = 16'h0001;
    localparam logic [15:0] FL_ACK      = 16'h0002;
    localparam logic [15:0] FL_FIN      = 16'h0004;
    localparam logic [15:0] FL_DATA     = 16'h0008;
    localparam logic [15:0] FL_FILENAME = 16'h0010;
    localparam logic [15:0] FL_CLOSE    = 16'h0020;

    typedef enum logic [1:0] {
        KIND_ACK    = 2'd0,
        KIND_SYNACK = 2'd1,
        KIND_FIN    = 2'd2,
        KIND_CLOSED = 2'd3
    } t_kind;

    typedef struct packed {
        logic        done;
        logic        valid;
        logic [31:0] seq;
        logic [15:0] flags;
        logic [15:0] length;
    } t_frame;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] ack;
        logic [5:0]  flags;
        logic        commit;
        logic [10:0] length;
        logic        start;
        logic        last;
    } t_result;

endpackage

### src/reliable_transfer_receiver.sv
// ----------------------------------------------------------------------------
// Reliable transfer receiver
// Go-back-N receiver that checks the Internet checksum of each frame and
// answers valid frames with ack, syn-ack, fin and session-closed replies.
// ----------------------------------------------------------------------------
// Frame words are taken one per cycle into an input register; the checksum
// add and the header capture for that word complete in the next cycle, and
// the replies caused by a frame's last word are pushed into a four-entry result
// queue while that word sits in the input register, ready on the master stream at once.
// The slave side stalls only while a last word sits in the input register and
// the queue is not empty, or while the queue holds more than two results. With
// the master side ready the block takes one word per cycle, except that a
// frame of one or two words ending right after the replies of the previous
// frame stalls the slave side.
module reliable_transfer_receiver #(
    parameter int FRAME_WORDS   = rtr_pkg::FRAME_WORDS_DEF,
    parameter int PAYLOAD_BYTES = rtr_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] frame_word
    input  logic        i_s_tlast,   // frame_end
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,   // [31:0] reply_ack_number, [37:32] reply_flags,
                                     // [38] payload_commit, [49:39] payload_length,
                                     // [50] file_start, [55:51] zero
    output logic [1:0]  o_m_tuser,   // [1:0] reply_kind
    output logic        o_m_tlast    // last_result
);
    import rtr_pkg::*;

    localparam int CNT_W = $clog2(Q_DEPTH) + 1;

    t_frame           frame;
    logic             end_pending;
    logic [1:0]       push;
    t_result          res0, res1, res_out;
    logic [CNT_W-1:0] count;
    logic [CNT_W:0]   need;

    assign need       = {1'b0, count} + (end_pending ? (CNT_W + 1)'(2) : '0);
    assign o_s_tready = (need <= (CNT_W + 1)'(Q_DEPTH - 2));

    rtr_frame_parse #(
        .FRAME_WORDS (FRAME_WORDS)
    ) u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_s_tvalid),
        .i_ready       (o_s_tready),
        .i_word        (i_s_tdata),
        .i_end         (i_s_tlast),
        .o_end_pending (end_pending),
        .o_frame       (frame)
    );

    rtr_rules #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_rules (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_frame (frame),
        .o_push  (push),
        .o_res0  (res0),
        .o_res1  (res1)
    );

    rtr_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res0  (res0),
        .i_res1  (res1),
        .i_ready (i_m_tready),
        .o_valid (o_m_tvalid),
        .o_res   (res_out),
        .o_count (count)
    );

    assign o_m_tdata = {5'd0, res_out.start, res_out.length, res_out.commit,
                        res_out.flags, res_out.ack};
    assign o_m_tuser = res_out.kind;
    assign o_m_tlast = res_out.last;

endmodule

### src/rtr_frame_parse.sv
// ----------------------------------------------------------------------------
// Frame parser
// Registers each incoming word, captures the header fields, accumulates the
// ones' complement checksum and reports the frame at its last word.
// ----------------------------------------------------------------------------
module rtr_frame_parse #(
    parameter int FRAME_WORDS = rtr_pkg::FRAME_WORDS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_ready,
    input  logic [15:0]    i_word,
    input  logic           i_end,
    output logic           o_end_pending,
    output rtr_pkg::t_frame o_frame
);
    import rtr_pkg::*;

    localparam int IDX_W = $clog2(FRAME_WORDS);

    logic              r_iv;
    logic [15:0]       r_word;
    logic              r_end;
    logic [IDX_W-1:0]  r_index, n_index;
    logic [15:0]       r_sum, n_sum;
    logic              r_overrun, n_overrun;
    logic [31:0]       r_seq, n_seq;
    logic [15:0]       r_flags, n_flags;
    logic [15:0]       r_length, n_length;
    logic [15:0]       r_csum, n_csum;
    logic [16:0]       sum_wide;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
        end else begin
            r_iv <= i_valid && i_ready;
        end
        if (i_valid && i_ready) begin
            r_word <= i_word;
            r_end  <= i_end;
        end
    end

    always_comb begin
        n_index   = r_index;
        n_sum     = r_sum;
        n_overrun = r_overrun;
        n_seq     = r_seq;
        n_flags   = r_flags;
        n_length  = r_length;
        n_csum    = r_csum;
        sum_wide  = {1'b0, r_sum};
        o_frame   = '0;
        if (r_iv) begin
            if (!r_overrun) begin
                if (r_index == IDX_W'(WORD_SEQ_LO)) n_seq[15:0]  = r_word;
                if (r_index == IDX_W'(WORD_SEQ_HI)) n_seq[31:16] = r_word;
                if (r_index == IDX_W'(WORD_FLAGS))  n_flags      = r_word;
                if (r_index == IDX_W'(WORD_LENGTH)) n_length     = r_word;
                if (r_index == IDX_W'(WORD_CSUM)) begin
                    n_csum = r_word;
                end else begin
                    sum_wide = {1'b0, r_sum} + {1'b0, r_word};
                end
                n_sum = sum_wide[15:0] + {15'd0, sum_wide[16]};
                if (!r_end) begin
                    if (r_index >= IDX_W'(FRAME_WORDS - 1)) begin
                        n_overrun = 1'b1;
                    end else begin
                        n_index = r_index + IDX_W'(1);
                    end
                end
            end
            if (r_end) begin
                o_frame.done   = 1'b1;
                o_frame.valid  = !r_overrun && (r_index >= IDX_W'(WORD_CSUM))
                                 && ((~n_sum) == n_csum);
                o_frame.seq    = n_seq;
                o_frame.flags  = n_flags;
                o_frame.length = n_length;
                n_index   = '0;
                n_sum     = '0;
                n_overrun = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index   <= '0;
            r_sum     <= '0;
            r_overrun <= 1'b0;
            r_seq     <= '0;
            r_flags   <= '0;
            r_length  <= '0;
            r_csum    <= '0;
        end else begin
            r_index   <= n_index;
            r_sum     <= n_sum;
            r_overrun <= n_overrun;
            r_seq     <= n_seq;
            r_flags   <= n_flags;
            r_length  <= n_length;
            r_csum    <= n_csum;
        end
    end

    assign o_end_pending = r_iv && r_end;

    a_overrun_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_overrun |-> (r_index == IDX_W'(FRAME_WORDS - 1)))
        else $error("Overrun set away from the last word position.");

endmodule

### src/rtr_rules.sv
// ----------------------------------------------------------------------------
// Receiver rules
// Applies the go-back-N receiver rules and the close handshake to each
// finished frame and produces zero, one or two reply results.
// ----------------------------------------------------------------------------
module rtr_rules #(
    parameter int PAYLOAD_BYTES = rtr_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rtr_pkg::t_frame i_frame,
    output logic [1:0]      o_push,
    output rtr_pkg::t_result o_res0,
    output rtr_pkg::t_result o_res1
);
    import rtr_pkg::*;

    logic [31:0] r_expected, n_expected;
    logic        r_file_active, n_file_active;
    logic        r_await, n_await;
    logic        r_closed, n_closed;
    logic [31:0] next_seq;
    logic        in_order;
    logic [10:0] sat_len;

    assign next_seq = i_frame.seq + 32'd1;
    assign in_order = (i_frame.seq == r_expected);
    assign sat_len  = (i_frame.length > 16'(PAYLOAD_BYTES)) ? 11'(PAYLOAD_BYTES)
                                                           : i_frame.length[10:0];

    always_comb begin
        n_expected    = r_expected;
        n_file_active = r_file_active;
        n_await       = r_await;
        n_closed      = r_closed;
        o_push        = 2'd0;
        o_res0        = '0;
        o_res1        = '0;
        o_res0.last   = 1'b1;
        if (i_frame.done && !r_closed) begin
            if (r_await) begin
                n_await = 1'b0;
                if (i_frame.valid && ((i_frame.flags & FL_ACK) != '0)) begin
                    n_closed    = 1'b1;
                    o_push      = 2'd1;
                    o_res0.kind = KIND_CLOSED;
                end
            end else if (i_frame.valid) begin
                priority if ((i_frame.flags & FL_SYN) != '0) begin
                    o_push       = 2'd1;
                    o_res0.kind  = KIND_SYNACK;
                    o_res0.ack   = next_seq;
                    o_res0.flags = 6'(FL_SYN | FL_ACK);
                end else if ((i_frame.flags & FL_FILENAME) != '0) begin
                    o_push       = 2'd1;
                    o_res0.kind  = KIND_ACK;
                    o_res0.flags = 6'(FL_ACK);
                    if (in_order) begin
                        o_res0.ack    = next_seq;
                        o_res0.start  = 1'b1;
                        n_file_active = 1'b1;
                        n_expected    = r_expected + 32'd1;
                    end else begin
                        o_res0.ack = r_expected;
                    end
                end else if ((i_frame.flags & FL_DATA) != '0) begin
                    o_res0.kind  = KIND_ACK;
                    o_res0.flags = 6'(FL_ACK);
                    if (!in_order) begin
                        o_push     = 2'd1;
                        o_res0.ack = r_expected;
                    end else if (r_file_active) begin
                        o_push        = 2'd1;
                        o_res0.ack    = next_seq;
                        o_res0.commit = 1'b1;
                        o_res0.length = sat_len;
                        n_expected    = r_expected + 32'd1;
                    end
                end else if ((i_frame.flags & FL_FIN) != '0) begin
                    o_push        = 2'd1;
                    o_res0.kind   = KIND_ACK;
                    o_res0.ack    = next_seq;
                    o_res0.flags  = 6'(FL_ACK);
                    n_file_active = 1'b0;
                    n_expected    = '0;
                end else if ((i_frame.flags & FL_CLOSE) != '0) begin
                    o_push       = 2'd2;
                    o_res0.kind  = KIND_ACK;
                    o_res0.ack   = next_seq;
                    o_res0.flags = 6'(FL_ACK);
                    o_res0.last  = 1'b0;
                    o_res1.kind  = KIND_FIN;
                    o_res1.flags = 6'(FL_FIN);
                    o_res1.last  = 1'b1;
                    n_await      = 1'b1;
                end else begin
                    o_push = 2'd0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected    <= '0;
            r_file_active <= 1'b0;
            r_await       <= 1'b0;
            r_closed      <= 1'b0;
        end else begin
            r_expected    <= n_expected;
            r_file_active <= n_file_active;
            r_await       <= n_await;
            r_closed      <= n_closed;
        end
    end

    a_closed_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_closed |-> (o_push == 2'd0))
        else $error("Result produced after the session closed.");

    a_pair_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push == 2'd2) |-> (!o_res0.last && o_res1.last && !r_await))
        else $error("Two-result reply is malformed.");

endmodule

### src/rtr_out_queue.sv
// ----------------------------------------------------------------------------
// Result queue
// Small circular buffer that takes up to two results per cycle and hands
// them out one word at a time on the master stream.
// ----------------------------------------------------------------------------
module rtr_out_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [1:0]                    i_push,
    input  rtr_pkg::t_result              i_res0,
    input  rtr_pkg::t_result              i_res1,
    input  logic                          i_ready,
    output logic                          o_valid,
    output rtr_pkg::t_result              o_res,
    output logic [$clog2(rtr_pkg::Q_DEPTH):0] o_count
);
    import rtr_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);

    t_result          r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [PTR_W:0]   r_count, n_count;
    logic             pop;

    assign pop = (r_count != '0) && i_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr + PTR_W'(i_push);
        n_rd_ptr = r_rd_ptr + PTR_W'(pop);
        n_count  = r_count + (PTR_W + 1)'(i_push) - (PTR_W + 1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push != 2'd0) begin
            r_mem[r_wr_ptr] <= i_res0;
        end
        if (i_push == 2'd2) begin
            r_mem[r_wr_ptr + PTR_W'(1)] <= i_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_res   = r_mem[r_rd_ptr];
    assign o_count = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_count} + {1'b0, (PTR_W + 1)'(i_push)}) <= (PTR_W + 2)'(Q_DEPTH))
        else $error("Result queue overflow.");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != (PTR_W + 1)'(Q_DEPTH)) |-> (PTR_W'(r_wr_ptr - r_rd_ptr) == r_count[PTR_W-1:0]))
        else $error("Queue pointers disagree with the fill count.");

endmodule
